### rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants of the segment subset-sum counter
// Field widths, the prime modulus, register indexes, controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  localparam int unsigned VAL_W      = 16;  // item value
  localparam int unsigned TGT_W      = 13;  // target sum register
  localparam int unsigned CNT_W      = 16;  // item count register
  localparam int unsigned IDX_W      = 16;  // item index
  localparam int unsigned ANS_W      = 30;  // residues and table entries
  localparam int unsigned SUM_W      = 17;  // clamped target, holds up to 65536
  localparam int unsigned PROD_W     = IDX_W + ANS_W;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned MAX_SUM_DEF   = 4096;
  localparam int unsigned MAX_ITEMS_DEF = 65535;

  localparam logic [ANS_W-1:0] MODULUS = 30'd998244353;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_SUM = 1'b0,
    REG_ITEM_COUNT = 1'b1
  } ssc_reg_e;

  typedef enum logic [3:0] {
    ST_BOOT_CLR,
    ST_IDLE,
    ST_DISPATCH,
    ST_RUN_CLR,
    ST_CHECK,
    ST_TOP_RD,
    ST_MUL,
    ST_MOD,
    ST_ACC,
    ST_WALK,
    ST_DRAIN,
    ST_SELF_RD,
    ST_SELF_WR,
    ST_INC,
    ST_FINISH
  } ssc_state_e;

  typedef struct packed {
    logic load_item;
    logic clear_init;
    logic clr_step;
    logic check;
    logic top_read;
    logic mul_start;
    logic mul_sel_idx;
    logic acc;
    logic walk_step;
    logic self_read;
    logic self_write;
    logic idx_inc;
    logic out_load;
  } ssc_cmd_t;

  typedef struct packed {
    logic start_flag;
    logic clr_last;
    logic overrun;
    logic case_walk;
    logic case_eq;
    logic walk_end;
    logic mod_done;
    logic out_free;
  } ssc_status_t;

  // sum of two residues, reduced once
  function automatic logic [ANS_W-1:0] mod_add(input logic [ANS_W-1:0] a,
                                               input logic [ANS_W-1:0] b);
    logic [ANS_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, MODULUS}) begin
      t = t - {1'b0, MODULUS};
    end
    return t[ANS_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/segment_subset_sum_counter_unit.sv
// ----------------------------------------------------------------------------
// segment_subset_sum_counter_unit: weighted subset-sum counter, top level
// Controller and datapath of the modulo 998244353 segment subset-sum count.
// ----------------------------------------------------------------------------
// After reset the count table is swept to zero, one entry a cycle, before
// the first item is taken; an item with start_new set triggers the same
// sweep before it is processed. One item at a time is worked on. For an
// item whose nonzero value v lies below the clamped target s, the answer
// term goes through a reciprocal reduction, then the table walk folds one
// entry per cycle through the dual-read count memory. A new item is
// accepted while the previous result still waits in the output register;
// the unit holds in its last step until that register is free.
// Configuration writes are always accepted and must only be issued while
// the unit is idle.
`default_nettype none

module segment_subset_sum_counter_unit #(
  parameter int unsigned MAX_SUM   = ssc_pkg::MAX_SUM_DEF,
  parameter int unsigned MAX_ITEMS = ssc_pkg::MAX_ITEMS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,   // item_value
  input  logic [0:0]                     s_axis_tuser,   // start_new
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,   // running_answer, zero pad
  output logic [0:0]                     m_axis_tuser,   // overrun
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ssc_pkg::*;

  ssc_cmd_t         cmd;
  ssc_status_t      status;
  logic [ANS_W-1:0] answer;
  logic             overrun;

  assign cfg_ready_o = 1'b1;

  ssc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssc_datapath #(
    .MAX_SUM   (MAX_SUM),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .item_value_i     (s_axis_tdata),
    .start_new_i      (s_axis_tuser[0]),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .running_answer_o (answer),
    .overrun_o        (overrun)
  );

  assign m_axis_tdata = {2'b00, answer};
  assign m_axis_tuser = overrun;

endmodule

`default_nettype wire

### rtl/ssc_table.sv
// ----------------------------------------------------------------------------
// ssc_table: subset-sum count memory
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_table #(
  parameter int unsigned DEPTH = ssc_pkg::MAX_SUM_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [ssc_pkg::ANS_W-1:0] wdata_i,
  input  logic                     re_a_i,
  input  logic [AW-1:0]            raddr_a_i,
  output logic [ssc_pkg::ANS_W-1:0] rdata_a_o,
  input  logic                     re_b_i,
  input  logic [AW-1:0]            raddr_b_i,
  output logic [ssc_pkg::ANS_W-1:0] rdata_b_o
);
  import ssc_pkg::*;

  logic [ANS_W-1:0] mem [DEPTH];
  logic [ANS_W-1:0] rdata_a_q;
  logic [ANS_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_q <= mem[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

### rtl/ssc_modred.sv
// ----------------------------------------------------------------------------
// ssc_modred: weight times term, reduced modulo the prime
// Registered multiply, then a reciprocal estimate of the quotient and one
// corrective subtract of up to two moduli, each step registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_modred (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ssc_pkg::IDX_W-1:0] weight_i,
  input  logic [ssc_pkg::ANS_W-1:0] term_i,
  output logic [ssc_pkg::ANS_W-1:0] rem_o,
  output logic                      done_o
);
  import ssc_pkg::*;

  // top product bits feed the estimate, the quotient fits the same width
  localparam int unsigned QW   = PROD_W - ANS_W + 1;
  localparam int unsigned MU_W = ANS_W + 1;
  localparam int unsigned RW   = ANS_W + 2;
  localparam logic [63:0] MU_FULL = (64'd1 << (2 * ANS_W)) / 64'(MODULUS);
  localparam logic [MU_W-1:0] MU      = MU_FULL[MU_W-1:0];
  localparam logic [RW-1:0]   ONE_M   = {2'b00, MODULUS};
  localparam logic [RW-1:0]   TWO_M   = {1'b0, MODULUS, 1'b0};
  localparam logic [RW-1:0]   THREE_M = ONE_M + TWO_M;

  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [QW-1:0]      quo_q, quo_d;
  logic [RW-1:0]      r_q, r_d;
  logic [ANS_W-1:0]   rem_q, rem_d;
  logic [1:0]         stg_q, stg_d;
  logic [QW+MU_W-1:0] quo_est;
  logic [PROD_W-1:0]  quo_mul;

  assign quo_est = (QW+MU_W)'(prod_q[PROD_W-1 -: QW]) * (QW+MU_W)'(MU);
  assign quo_mul = PROD_W'(quo_q) * PROD_W'(MODULUS);

  always_comb begin
    prod_d = prod_q;
    quo_d  = quo_q;
    r_d    = r_q;
    rem_d  = rem_q;
    stg_d  = stg_q;
    if (start_i) begin
      prod_d = PROD_W'(weight_i) * PROD_W'(term_i);
      stg_d  = 2'd3;
    end else begin
      case (stg_q)
        2'd3: begin
          // estimate falls short of the true quotient by at most two
          quo_d = QW'(quo_est >> (ANS_W + 1));
          stg_d = 2'd2;
        end
        2'd2: begin
          r_d   = RW'(prod_q - quo_mul);
          stg_d = 2'd1;
        end
        2'd1: begin
          if (r_q >= TWO_M) begin
            rem_d = ANS_W'(r_q - TWO_M);
          end else if (r_q >= ONE_M) begin
            rem_d = ANS_W'(r_q - ONE_M);
          end else begin
            rem_d = r_q[ANS_W-1:0];
          end
          stg_d = 2'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else begin
      stg_q <= stg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    quo_q  <= quo_d;
    r_q    <= r_d;
    rem_q  <= rem_d;
  end

  assign rem_o  = rem_q;
  assign done_o = (stg_q == 2'd0);

  a_partial_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_q == 2'd1) |-> (r_q < THREE_M))
    else $error("partial remainder above three moduli");

  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_q == 2'd1 && !start_i) |=> (rem_q < MODULUS))
    else $error("remainder left the residue range");

endmodule

`default_nettype wire

### rtl/ssc_datapath.sv
// ----------------------------------------------------------------------------
// ssc_datapath: registers, count table and arithmetic of the counter
// Holds configuration, item index, answer and the result register; walks the
// table under command of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_datapath #(
  parameter int unsigned MAX_SUM   = ssc_pkg::MAX_SUM_DEF,
  parameter int unsigned MAX_ITEMS = ssc_pkg::MAX_ITEMS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ssc_pkg::VAL_W-1:0]      item_value_i,
  input  logic                           start_new_i,
  input  ssc_pkg::ssc_cmd_t              cmd_i,
  output ssc_pkg::ssc_status_t           status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ssc_pkg::ANS_W-1:0]      running_answer_o,
  output logic                           overrun_o
);
  import ssc_pkg::*;

  localparam int unsigned AW = (MAX_SUM > 1) ? $clog2(MAX_SUM) : 1;

  logic [TGT_W-1:0] target_q;
  logic [CNT_W-1:0] count_q;
  logic [VAL_W-1:0] val_q;
  logic             start_q;
  logic [IDX_W-1:0] idx_q;
  logic [ANS_W-1:0] ans_q;
  logic             ovr_q;
  logic [AW-1:0]    clr_q;
  logic [AW-1:0]    j_q;
  logic             wv_q;
  logic [AW-1:0]    wa_q;
  logic             out_valid_q;
  logic [ANS_W-1:0] out_ans_q;
  logic             out_ovr_q;

  logic [SUM_W-1:0] s_lim;
  logic [IDX_W-1:0] limit;
  logic [IDX_W-1:0] weight;
  logic [ANS_W-1:0] idx_p1;
  logic [AW-1:0]    j0;
  logic [AW-1:0]    jm1;
  logic             overrun;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [ANS_W-1:0] wdata;
  logic             re_a, re_b;
  logic [AW-1:0]    raddr_a, raddr_b;
  logic [ANS_W-1:0] rdata_a, rdata_b;
  logic [ANS_W-1:0] mod_rem;
  logic             mod_done;

  // configuration, to be written only while idle by the user; not enforced here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TGT_W'(1);
      count_q  <= CNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TARGET_SUM: target_q <= cfg_data_i[TGT_W-1:0];
        REG_ITEM_COUNT: count_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_lim   = (SUM_W'(target_q) < SUM_W'(MAX_SUM)) ? SUM_W'(target_q) : SUM_W'(MAX_SUM);
  assign limit   = (32'(count_q) < 32'(MAX_ITEMS)) ? count_q : IDX_W'(MAX_ITEMS);
  assign overrun = (idx_q >= limit);
  assign weight  = limit - idx_q;
  assign idx_p1  = ANS_W'(idx_q) + ANS_W'(1);
  assign j0      = AW'(s_lim - SUM_W'(val_q));
  assign jm1     = j_q - AW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      val_q   <= item_value_i;
      start_q <= start_new_i;
    end
    if (cmd_i.check) begin
      ovr_q <= overrun;
    end
    if (cmd_i.top_read) begin
      j_q <= j0;
    end else if (cmd_i.walk_step) begin
      j_q <= jm1;
    end
    wa_q <= AW'(SUM_W'(jm1) + SUM_W'(val_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ans_q <= '0;
      clr_q <= '0;
      wv_q  <= 1'b0;
    end else begin
      wv_q <= cmd_i.walk_step;
      if (cmd_i.clear_init) begin
        idx_q <= '0;
        ans_q <= '0;
        clr_q <= '0;
      end else begin
        if (cmd_i.clr_step) begin
          clr_q <= clr_q + AW'(1);
        end
        if (cmd_i.idx_inc) begin
          idx_q <= idx_q + IDX_W'(1);
        end
        if (cmd_i.acc) begin
          ans_q <= mod_add(ans_q, mod_rem);
        end
      end
    end
  end

  // table ports: sweep zeros, own entry update, or the fold behind the walk
  always_comb begin
    we    = 1'b0;
    waddr = wa_q;
    wdata = mod_add(rdata_a, rdata_b);
    if (cmd_i.clr_step) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (cmd_i.self_write) begin
      we    = 1'b1;
      waddr = AW'(val_q);
      wdata = mod_add(rdata_a, idx_p1);
    end else if (wv_q) begin
      we = 1'b1;
    end
  end

  assign re_a    = cmd_i.top_read | cmd_i.walk_step | cmd_i.self_read;
  assign re_b    = cmd_i.walk_step;
  assign raddr_a = cmd_i.top_read ? j0 : (cmd_i.self_read ? AW'(val_q) : jm1);
  assign raddr_b = AW'(SUM_W'(jm1) + SUM_W'(val_q));

  ssc_table #(
    .DEPTH (MAX_SUM),
    .AW    (AW)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_a_i    (re_a),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .re_b_i    (re_b),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  ssc_modred u_modred (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mul_start),
    .weight_i (weight),
    .term_i   (cmd_i.mul_sel_idx ? idx_p1 : rdata_a),
    .rem_o    (mod_rem),
    .done_o   (mod_done)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ans_q <= ans_q;
      out_ovr_q <= ovr_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign running_answer_o = out_ans_q;
  assign overrun_o        = out_ovr_q;

  assign status_o.start_flag = start_q;
  assign status_o.clr_last   = (clr_q == AW'(MAX_SUM - 1));
  assign status_o.overrun    = overrun;
  assign status_o.case_walk  = (val_q != '0) && (SUM_W'(val_q) < s_lim);
  assign status_o.case_eq    = (val_q != '0) && (SUM_W'(val_q) == s_lim);
  assign status_o.walk_end   = (j_q <= AW'(1));
  assign status_o.mod_done   = mod_done;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  a_answer_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ans_q < MODULUS)
    else $error("answer left the residue range");

  a_fold_write_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wv_q |-> (!cmd_i.clr_step && !cmd_i.self_write))
    else $error("table write port claimed twice");

endmodule

`default_nettype wire

### rtl/ssc_ctrl.sv
// ----------------------------------------------------------------------------
// ssc_ctrl: sequencing controller of the counter
// Steps each item through clear (on start_new), check, answer update, table
// walk and own entry update, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ssc_pkg::ssc_status_t status_i,
  output ssc_pkg::ssc_cmd_t    cmd_o
);
  import ssc_pkg::*;

  ssc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BOOT_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_BOOT_CLR: if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:     if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: state_d = status_i.start_flag ? ST_RUN_CLR : ST_CHECK;
      ST_RUN_CLR:  if (status_i.clr_last) state_d = ST_CHECK;
      ST_CHECK: begin
        if (status_i.overrun) begin
          state_d = ST_FINISH;
        end else if (status_i.case_walk) begin
          state_d = ST_TOP_RD;
        end else if (status_i.case_eq) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_INC;
        end
      end
      ST_TOP_RD:   state_d = ST_MUL;
      ST_MUL:      state_d = ST_MOD;
      ST_MOD:      if (status_i.mod_done) state_d = ST_ACC;
      ST_ACC:      state_d = status_i.case_walk ? ST_WALK : ST_INC;
      ST_WALK:     if (status_i.walk_end) state_d = ST_DRAIN;
      ST_DRAIN:    state_d = ST_SELF_RD;
      ST_SELF_RD:  state_d = ST_SELF_WR;
      ST_SELF_WR:  state_d = ST_INC;
      ST_INC:      state_d = ST_FINISH;
      ST_FINISH:   if (status_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_BOOT_CLR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_DISPATCH: cmd_o.clear_init = status_i.start_flag;
      ST_RUN_CLR:  cmd_o.clr_step = 1'b1;
      ST_CHECK:    cmd_o.check = 1'b1;
      ST_TOP_RD:   cmd_o.top_read = 1'b1;
      ST_MUL: begin
        cmd_o.mul_start   = 1'b1;
        cmd_o.mul_sel_idx = !status_i.case_walk;
      end
      ST_MOD:      ;
      ST_ACC:      cmd_o.acc = 1'b1;
      ST_WALK:     cmd_o.walk_step = !status_i.walk_end;
      ST_DRAIN:    ;
      ST_SELF_RD:  cmd_o.self_read = 1'b1;
      ST_SELF_WR:  cmd_o.self_write = 1'b1;
      ST_INC:      cmd_o.idx_inc = 1'b1;
      ST_FINISH:   cmd_o.out_load = status_i.out_free;
      default:     ;
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DISPATCH))
    else $error("accepted item not dispatched");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && status_i.out_free) |=> (state_q == ST_IDLE))
    else $error("result not handed over");

endmodule

`default_nettype wire
